@@ rtl/heightmap_vertex_normals_defines.svh @@
// ----------------------------------------------------------------------------
// Heightmap vertex normals assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_NORMALS_DEFINES_SVH
`define HEIGHTMAP_VERTEX_NORMALS_DEFINES_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge.
`define HVN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition in one cycle that implies another in the next cycle.
`define HVN_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define HVN_ASSERT(lbl, prop, msg)
`define HVN_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ rtl/hvn_pkg.sv @@
// ----------------------------------------------------------------------------
// Heightmap vertex normals package
// Widths, codes and shared types of the vertex normal generator.
// ----------------------------------------------------------------------------
package hvn_pkg;

	localparam int MAX_WIDTH = 256;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int CFG_W     = 9;
	localparam int EW        = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
	localparam int FACE_W    = 9;
	localparam int SUM_W     = 11;
	localparam int ABS_W     = 10;
	localparam int SQ_W      = 20;
	localparam int LEN_W     = 21;
	localparam int D_W       = 17;
	localparam int DSQ_W     = 34;
	localparam int PROD_W    = DSQ_W + LEN_W;
	localparam int FRAC_SH   = 32;
	localparam int Q_W       = 16;
	localparam int FACE_Y    = 15;
	localparam int QUEUE_DEPTH = 2;

	// Input item kinds.
	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_FLUSH  = 1'b1
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_GRID_WIDTH = 2'd0,
		CFG_GRID_ROWS  = 2'd1
	} cfg_index_t;

	// One face: x and z components, y is implied.
	typedef struct packed {
		logic signed [FACE_W-1:0] fx;
		logic signed [FACE_W-1:0] fz;
	} face_t;

	// Face sum handed from the front to the normaliser.
	typedef struct packed {
		logic signed [SUM_W-1:0] sx;
		logic signed [SUM_W-1:0] sz;
		logic [2:0]              cnt;
		logic                    last;
	} face_sum_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_READ,
		F_EXEC
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SQUARE,
		B_LEN,
		B_MUL1,
		B_MUL2,
		B_CMP,
		B_OUT
	} back_state_t;

endpackage

@@ rtl/hvn_ram.sv @@
// ----------------------------------------------------------------------------
// Generic line RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hvn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/hvn_queue.sv @@
// ----------------------------------------------------------------------------
// Face sum queue
// Short FIFO that decouples the line buffer front from the normaliser.
// ----------------------------------------------------------------------------
module hvn_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  hvn_pkg::face_sum_t    push_data,
	input  logic                  pop,
	output hvn_pkg::face_sum_t    pop_data,
	output hvn_pkg::queue_status_t status
);
	import hvn_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	face_sum_t        entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	// Status and head of the queue.
	assign status.full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/hvn_front.sv @@
// ----------------------------------------------------------------------------
// Line buffer front end
// Tracks the raster position, reads the height and face lines and forms the
// face sum of each vertex for the normaliser.
// ----------------------------------------------------------------------------
module hvn_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [1:0]             cfg_index,
	input  logic [hvn_pkg::CFG_W-1:0] cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   kind,
	input  logic [7:0]             height,
	input  hvn_pkg::queue_status_t q_status,
	output logic                   q_push,
	output hvn_pkg::face_sum_t     q_data
);
	import hvn_pkg::*;

	front_state_t state_q, state_d;

	logic [CFG_W-1:0] grid_width_q;
	logic [CFG_W-1:0] grid_rows_q;
	logic [COL_W-1:0] col_q;
	logic [CFG_W-1:0] row_q;
	face_t            left_q;

	logic [COL_W-1:0] col_x_q;
	logic             kind_q;
	logic [7:0]       h_q;
	logic [7:0]       h00_q;
	face_t            fleft_q;

	logic [EW-1:0]    w_eff;
	logic [CFG_W-1:0] rows_eff;
	logic [COL_W-1:0] col_cur;
	logic [COL_W-1:0] h_raddr;
	logic [COL_W-1:0] f_raddr;
	logic [7:0]       h_rdata;
	face_t            f_rdata;
	logic             h_we;
	logic             f_we;
	logic             have_left;
	logic             have_right;
	logic             last_col;
	logic             flushing;
	logic             produce;
	logic             advance;
	logic             accept;
	logic             cfg_hit;
	face_t            new_face;
	logic signed [SUM_W-1:0] sx;
	logic signed [SUM_W-1:0] sz;
	logic [2:0]       cnt;

	// Effective geometry, clamped to the supported range.
	always_comb begin
		if (EW'(grid_width_q) < EW'(2)) begin
			w_eff = EW'(2);
		end else if (EW'(grid_width_q) > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(grid_width_q);
		end
		rows_eff = (grid_rows_q < CFG_W'(2)) ? CFG_W'(2) : grid_rows_q;
	end

	assign col_cur    = (EW'(col_q) >= w_eff) ? '0 : col_q;
	assign have_left  = (col_x_q != '0);
	assign have_right = (EW'(col_x_q) < w_eff - EW'(1));
	assign last_col   = (EW'(col_x_q) == w_eff - EW'(1));
	assign flushing   = (row_q >= rows_eff);
	assign accept     = in_valid && !in_stall;
	assign cfg_hit    = cfg_valid &&
		(cfg_index == CFG_GRID_WIDTH || cfg_index == CFG_GRID_ROWS);

	// Line buffers of heights and faces from the previous row.
	hvn_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_height_line (
		.clk   (clk),
		.we    (h_we),
		.waddr (col_x_q),
		.wdata (h_q),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	hvn_ram #(.WIDTH(2*FACE_W), .DEPTH(MAX_WIDTH)) u_face_line (
		.clk   (clk),
		.we    (f_we),
		.waddr (col_x_q - 1'b1),
		.wdata (left_q),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	// Face sum of the vertex above a sample, or of a final-row vertex.
	always_comb begin
		new_face.fx = $signed({1'b0, h00_q}) - $signed({1'b0, h_rdata});
		new_face.fz = $signed({1'b0, h00_q}) - $signed({1'b0, h_q});
		sx  = '0;
		sz  = '0;
		cnt = '0;
		if (kind_q == KIND_SAMPLE) begin
			if (have_right) begin
				sx  = sx + SUM_W'(new_face.fx);
				sz  = sz + SUM_W'(new_face.fz);
				cnt = cnt + 3'd1;
			end
			if (have_left) begin
				sx  = sx + SUM_W'(left_q.fx);
				sz  = sz + SUM_W'(left_q.fz);
				cnt = cnt + 3'd1;
			end
		end
		if (kind_q == KIND_FLUSH || row_q >= CFG_W'(2)) begin
			if (have_left) begin
				sx  = sx + SUM_W'(fleft_q.fx);
				sz  = sz + SUM_W'(fleft_q.fz);
				cnt = cnt + 3'd1;
			end
			if (have_right) begin
				sx  = sx + SUM_W'(f_rdata.fx);
				sz  = sz + SUM_W'(f_rdata.fz);
				cnt = cnt + 3'd1;
			end
		end
		if (kind_q == KIND_FLUSH) begin
			produce = flushing;
		end else begin
			produce = !flushing && (row_q != '0);
		end
		q_data.sx   = sx;
		q_data.sz   = sz;
		q_data.cnt  = cnt;
		q_data.last = (kind_q == KIND_FLUSH) && last_col;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE:  if (accept) state_d = F_READ;
			F_READ:  state_d = F_EXEC;
			F_EXEC:  if (advance) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		in_stall = 1'b1;
		advance  = 1'b0;
		h_raddr  = col_x_q + 1'b1;
		f_raddr  = col_x_q;
		unique case (state_q)
			F_IDLE: begin
				in_stall = 1'b0;
				h_raddr  = col_cur;
				f_raddr  = col_cur - 1'b1;
			end
			F_READ: begin
			end
			F_EXEC: begin
				advance = !(produce && q_status.full);
			end
			default: begin
			end
		endcase
		q_push = advance && produce;
		h_we   = advance && (kind_q == KIND_SAMPLE) && !flushing;
		f_we   = h_we && (row_q != '0) && have_left;
	end

	// Per-item registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_x_q <= col_cur;
			kind_q  <= kind;
			h_q     <= height;
		end
		if (state_q == F_READ) begin
			h00_q   <= h_rdata;
			fleft_q <= f_rdata;
		end
	end

	// Control state, stream position and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			grid_width_q <= CFG_W'(256);
			grid_rows_q  <= CFG_W'(256);
			col_q        <= '0;
			row_q        <= '0;
			left_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_hit) begin
				col_q  <= '0;
				row_q  <= '0;
				left_q <= '0;
				if (cfg_index == CFG_GRID_WIDTH) begin
					grid_width_q <= cfg_data;
				end else begin
					grid_rows_q <= cfg_data;
				end
			end else if (advance) begin
				if (kind_q == KIND_SAMPLE && !flushing) begin
					if (row_q != '0) begin
						left_q <= have_right ? new_face : '0;
					end
					if (last_col) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_x_q + 1'b1;
					end
				end else if (kind_q == KIND_FLUSH && flushing) begin
					if (last_col) begin
						col_q  <= '0;
						row_q  <= '0;
						left_q <= '0;
					end else begin
						col_q <= col_x_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

@@ rtl/hvn_back.sv @@
// ----------------------------------------------------------------------------
// Normaliser back end
// Turns a face sum into a rounded Q1.15 unit vector bit by bit, with two
// multiplies and a compare per bit, and holds it in the output register.
// ----------------------------------------------------------------------------
`include "heightmap_vertex_normals_defines.svh"

module hvn_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hvn_pkg::queue_status_t q_status,
	input  hvn_pkg::face_sum_t     q_data,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [15:0]     normal_x,
	output logic signed [15:0]     normal_y,
	output logic signed [15:0]     normal_z,
	output logic                   last_vertex
);
	import hvn_pkg::*;

	back_state_t state_q, state_d;

	logic signed [SUM_W-1:0] sx_q;
	logic signed [SUM_W-1:0] sz_q;
	logic [5:0]         sy_q;
	logic               last_q;
	logic [SQ_W-1:0]    sqx_q, sqy_q, sqz_q;
	logic [LEN_W-1:0]   len2_q;
	logic [1:0]         comp_q;
	logic [3:0]         bit_q;
	logic [Q_W-1:0]     n_q;
	logic [DSQ_W-1:0]   dsq_q;
	logic [PROD_W-1:0]  prod_q;
	logic signed [Q_W-1:0] res_x_q, res_y_q, res_z_q;
	logic               out_valid_q;

	logic [ABS_W-1:0]   ax, az;
	logic [Q_W-1:0]     cand;
	logic [D_W-1:0]     d;
	logic [SQ_W-1:0]    sq_sel;
	logic               neg_sel;
	logic [Q_W-1:0]     n_next;
	logic [Q_W-1:0]     n_sat;
	logic signed [Q_W-1:0] res_val;
	logic               out_free;
	logic               load_out;

	assign ax       = ABS_W'(sx_q < 0 ? -sx_q : sx_q);
	assign az       = ABS_W'(sz_q < 0 ? -sz_q : sz_q);
	assign cand     = n_q | (Q_W'(1) << bit_q);
	assign d        = {cand, 1'b0} - D_W'(1);
	assign out_free = !out_valid_q || !out_stall;

	// Square and sign of the component in work.
	always_comb begin
		case (comp_q)
			2'd0: begin
				sq_sel  = sqx_q;
				neg_sel = sx_q < 0;
			end
			2'd1: begin
				sq_sel  = sqy_q;
				neg_sel = 1'b0;
			end
			default: begin
				sq_sel  = sqz_q;
				neg_sel = sz_q < 0;
			end
		endcase
	end

	// Keep the trial bit while the odd square bound stays at or under the target.
	always_comb begin
		n_next  = (prod_q <= (PROD_W'(sq_sel) << FRAC_SH)) ? cand : n_q;
		n_sat   = (n_next > Q_W'(32767)) ? Q_W'(32767) : n_next;
		res_val = neg_sel ? -$signed(n_sat) : $signed(n_sat);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:   if (!q_status.empty) state_d = B_SQUARE;
			B_SQUARE: state_d = B_LEN;
			B_LEN:    state_d = B_MUL1;
			B_MUL1:   state_d = B_MUL2;
			B_MUL2:   state_d = B_CMP;
			B_CMP: begin
				if (bit_q == '0 && comp_q == 2'd2) begin
					state_d = B_OUT;
				end else begin
					state_d = B_MUL1;
				end
			end
			B_OUT:    if (out_free) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		q_pop    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			B_IDLE:  q_pop = !q_status.empty;
			B_OUT:   load_out = out_free;
			default: begin
			end
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				sx_q   <= q_data.sx;
				sz_q   <= q_data.sz;
				sy_q   <= 6'(FACE_Y) * 6'(q_data.cnt);
				last_q <= q_data.last;
			end
			B_SQUARE: begin
				sqx_q <= SQ_W'(ax * ax);
				sqy_q <= SQ_W'(sy_q * sy_q);
				sqz_q <= SQ_W'(az * az);
			end
			B_LEN: begin
				len2_q <= LEN_W'(sqx_q) + LEN_W'(sqy_q) + LEN_W'(sqz_q);
				n_q    <= '0;
			end
			B_MUL1: dsq_q <= DSQ_W'(d * d);
			B_MUL2: prod_q <= PROD_W'(dsq_q * len2_q);
			B_CMP: begin
				if (bit_q == '0) begin
					n_q <= '0;
					case (comp_q)
						2'd0:    res_x_q <= res_val;
						2'd1:    res_y_q <= res_val;
						default: res_z_q <= res_val;
					endcase
				end else begin
					n_q <= n_next;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			normal_x    <= res_x_q;
			normal_y    <= res_y_q;
			normal_z    <= res_z_q;
			last_vertex <= last_q;
		end
	end

	// Control state, loop counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			comp_q      <= '0;
			bit_q       <= '1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_LEN) begin
				comp_q <= '0;
				bit_q  <= '1;
			end else if (state_q == B_CMP) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					comp_q <= comp_q + 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`HVN_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid_q, "result load lost")
	`HVN_ASSERT_NEXT(a_last_bit_ends, state_q == B_CMP && bit_q == '0 && comp_q == 2'd2,
		state_q == B_OUT, "normaliser did not finish after the last bit")
	`HVN_ASSERT(a_comp_range, state_q != B_MUL1 || comp_q != 2'd3,
		"component index out of range")
	`HVN_ASSERT(a_pop_only_idle, !q_pop || (state_q == B_IDLE && !q_status.empty),
		"queue popped outside idle")

endmodule

@@ rtl/heightmap_vertex_normals.sv @@
// ----------------------------------------------------------------------------
// Heightmap vertex normals
// Streams 8-bit heights in raster order and returns one unit vertex normal
// per grid point, one row behind the input.
// ----------------------------------------------------------------------------
// A height sample passes the front-end states idle, read and execute (two
// line-buffer reads and the face update), and no new request enters until
// it is done. The normaliser solves each output component bit by bit, with
// two multiplies and a compare per bit; that loop sets the sustained rate
// for requests that produce a normal. Samples of row 0, and requests that
// are ignored, pass at the front-end rate. A two-entry queue separates the
// two halves and an output register holds the last result while the next
// one is computed.
// ----------------------------------------------------------------------------
module heightmap_vertex_normals (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [7:0]         height,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               last_vertex
);
	import hvn_pkg::*;

	queue_status_t q_status;
	face_sum_t     push_data;
	face_sum_t     pop_data;
	logic          q_push;
	logic          q_pop;

	assign cfg_ready = 1'b1;

	// Position tracking and line buffers.
	hvn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.height    (height),
		.q_status  (q_status),
		.q_push    (q_push),
		.q_data    (push_data)
	);

	// Face sums waiting for the normaliser.
	hvn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	// Normaliser and output register.
	hvn_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.q_data      (pop_data),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z),
		.last_vertex (last_vertex)
	);

endmodule

@@ tb/sv/heightmap_vertex_normals_tb.sv @@
// ----------------------------------------------------------------------------
// Heightmap vertex normals testbench
// Streams height maps and flush requests through the normal generator, and
// checks every returned normal against a cycle-free predictor of the grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module heightmap_vertex_normals_tb;
	import hvn_pkg::*;

	localparam int  IDLE_WAIT = 300;
	localparam int  TARGET_ITEMS = 1550;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               last;
	} normal_t;

	// One directed request; typed is set where the normal is known by hand.
	typedef struct {
		kind_t       k;
		logic [7:0]  h;
		bit          typed;
		normal_t     n;
	} vector_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [8:0]         cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               kind;
	logic [7:0]         height;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic               last_vertex;

	heightmap_vertex_normals dut (.*);

	// Predictor state of the grid.
	logic [8:0]  grid_w_reg;
	logic [8:0]  grid_rows_reg;
	logic [7:0]  prev_heights[MAX_WIDTH];
	logic [17:0] prev_faces[MAX_WIDTH];
	logic [17:0] left_face_p;
	int          col_p;
	int          row_p;

	normal_t     pending_normals[$];
	int          error_count;
	int          items_sent;
	longint      cycle_count;

	localparam normal_t FLAT = '{nx: 16'sd0, ny: 16'sd32767, nz: 16'sd0, last: 1'b0};
	localparam normal_t FLAT_LAST = '{nx: 16'sd0, ny: 16'sd32767, nz: 16'sd0, last: 1'b1};

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_GRID_WIDTH;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		kind      <= KIND_SAMPLE;
		height    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Solve round(32768 * s / |S|) bit by bit, ties away from zero.
	function automatic logic signed [15:0] unit_comp(input int s, input longint unsigned len2);
		longint unsigned mag, lim, d, c, n;
		mag = (s < 0) ? -s : s;
		lim = (mag * mag) << 32;
		n = 0;
		for (int b = 15; b >= 0; b--) begin
			c = n | (64'd1 << b);
			d = 2 * c - 1;
			if (d * d * len2 <= lim)
				n = c;
		end
		if (n > 32767)
			n = 32767;
		return (s < 0) ? -16'(n) : 16'(n);
	endfunction

	function automatic normal_t unit_normal(input int sx, input int sy, input int sz,
			input bit last);
		longint unsigned len2;
		normal_t r;
		len2 = longint'(sx) * sx + longint'(sy) * sy + longint'(sz) * sz;
		r.nx = unit_comp(sx, len2);
		r.ny = unit_comp(sy, len2);
		r.nz = unit_comp(sz, len2);
		r.last = last;
		return r;
	endfunction

	// Advance the grid by one request; returns 1 when it yields a normal.
	function automatic bit predict_normal(input kind_t k, input logic [7:0] h,
			output normal_t r);
		int w, rows, col, sx, sz, cnt, fx, fz;
		bit flushing, has_l, has_r, made;
		logic [17:0] nf;
		w = (grid_w_reg < 2) ? 2 : (grid_w_reg > MAX_WIDTH) ? MAX_WIDTH : grid_w_reg;
		rows = (grid_rows_reg < 2) ? 2 : grid_rows_reg;
		col = (col_p >= w) ? 0 : col_p;
		flushing = row_p >= rows;
		has_l = col >= 1;
		has_r = col < w - 1;
		sx = 0; sz = 0; cnt = 0; made = 0; nf = '0;
		r = '0;
		if (k == KIND_SAMPLE) begin
			if (flushing)
				return 0;
			if (row_p >= 1) begin
				if (has_r) begin
					fx = int'(prev_heights[col]) - int'(prev_heights[col + 1]);
					fz = int'(prev_heights[col]) - int'(h);
					nf = {9'(fx), 9'(fz)};
					sx += fx; sz += fz; cnt++;
				end
				if (has_l) begin
					sx += $signed(left_face_p[17:9]); sz += $signed(left_face_p[8:0]); cnt++;
				end
				if (row_p >= 2) begin
					if (has_l) begin
						sx += $signed(prev_faces[col - 1][17:9]);
						sz += $signed(prev_faces[col - 1][8:0]);
						cnt++;
					end
					if (has_r) begin
						sx += $signed(prev_faces[col][17:9]);
						sz += $signed(prev_faces[col][8:0]);
						cnt++;
					end
				end
				r = unit_normal(sx, FACE_Y * cnt, sz, 1'b0);
				made = 1;
				if (has_l)
					prev_faces[col - 1] = left_face_p;
				left_face_p = nf;
			end
			prev_heights[col] = h;
			if (col == w - 1) begin
				col = 0;
				row_p++;
			end else
				col++;
		end else begin
			if (!flushing)
				return 0;
			if (has_l) begin
				sx += $signed(prev_faces[col - 1][17:9]);
				sz += $signed(prev_faces[col - 1][8:0]);
				cnt++;
			end
			if (has_r) begin
				sx += $signed(prev_faces[col][17:9]);
				sz += $signed(prev_faces[col][8:0]);
				cnt++;
			end
			r = unit_normal(sx, FACE_Y * cnt, sz, col == w - 1);
			made = 1;
			if (col == w - 1) begin
				col = 0;
				row_p = 0;
				left_face_p = '0;
			end else
				col++;
		end
		col_p = col;
		return made;
	endfunction

	// Wait until every normal has come back and the block has drained.
	task automatic wait_drained();
		while (pending_normals.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	// Write one register while the block is idle.
	task automatic write_reg(input cfg_index_t idx, input logic [8:0] value);
		in_valid <= 1'b0;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_GRID_WIDTH)
			grid_w_reg = value;
		else
			grid_rows_reg = value;
		col_p = 0;
		row_p = 0;
		left_face_p = '0;
	endtask

	// Offer one request, wait for it to be taken, then maybe leave a gap.
	task automatic send_request(input kind_t k, input logic [7:0] h, input bit typed,
			input normal_t typed_n);
		normal_t n;
		int r, gap;
		in_valid <= 1'b1;
		kind     <= k;
		height   <= h;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (predict_normal(k, h, n))
			pending_normals.push_back(typed ? typed_n : n);
		r = $urandom_range(0, 99);
		gap = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// One height map of the current geometry, with optional noise.
	task automatic send_map(input int w, input int rows, input bit noisy);
		int total;
		total = w * rows;
		for (int i = 0; i < total; i++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				send_request(KIND_FLUSH, 8'($urandom), 0, '0);
			send_request(KIND_SAMPLE, 8'($urandom), 0, '0);
		end
		for (int i = 0; i < w; i++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				send_request(KIND_SAMPLE, 8'($urandom), 0, '0);
			send_request(KIND_FLUSH, 8'($urandom), 0, '0);
		end
	endtask

	// Stimulus.
	initial begin
		vector_t vectors[$];
		int w, rows, mode;
		grid_w_reg = 9'd256;
		grid_rows_reg = 9'd256;
		col_p = 0;
		row_p = 0;
		left_face_p = '0;
		error_count = 0;
		items_sent = 0;
		@(posedge arst_n);
		@(posedge clk);

		// Flat 2x2 map, stray requests, then a map of extreme heights and one of mid heights.
		vectors = '{
			'{KIND_FLUSH,  8'd0,   1'b0, '0},
			'{KIND_SAMPLE, 8'd0,   1'b0, '0},
			'{KIND_SAMPLE, 8'd0,   1'b0, '0},
			'{KIND_SAMPLE, 8'd0,   1'b1, FLAT},
			'{KIND_SAMPLE, 8'd0,   1'b1, FLAT},
			'{KIND_SAMPLE, 8'd255, 1'b0, '0},
			'{KIND_FLUSH,  8'd0,   1'b1, FLAT},
			'{KIND_FLUSH,  8'd255, 1'b1, FLAT_LAST},
			'{KIND_SAMPLE, 8'd255, 1'b0, '0},
			'{KIND_SAMPLE, 8'd0,   1'b0, '0},
			'{KIND_SAMPLE, 8'd0,   1'b0, '0},
			'{KIND_SAMPLE, 8'd255, 1'b0, '0},
			'{KIND_FLUSH,  8'd0,   1'b0, '0},
			'{KIND_FLUSH,  8'd0,   1'b0, '0},
			'{KIND_SAMPLE, 8'd170, 1'b0, '0},
			'{KIND_SAMPLE, 8'd85,  1'b0, '0},
			'{KIND_SAMPLE, 8'd85,  1'b0, '0},
			'{KIND_SAMPLE, 8'd170, 1'b0, '0},
			'{KIND_FLUSH,  8'd0,   1'b0, '0},
			'{KIND_FLUSH,  8'd0,   1'b0, '0}
		};
		write_reg(CFG_GRID_WIDTH, 9'd2);
		write_reg(CFG_GRID_ROWS, 9'd2);
		foreach (vectors[i])
			send_request(vectors[i].k, vectors[i].h, vectors[i].typed, vectors[i].n);

		// Register write in the middle of a map restarts the stream.
		send_request(KIND_SAMPLE, 8'd7, 0, '0);
		send_request(KIND_SAMPLE, 8'd9, 0, '0);
		write_reg(CFG_GRID_ROWS, 9'd511);
		send_request(KIND_SAMPLE, 8'd1, 0, '0);
		write_reg(CFG_GRID_ROWS, 9'd3);
		send_map(2, 3, 0);

		// Extreme geometry: clamped to the widest and to the tallest-thin map.
		write_reg(CFG_GRID_WIDTH, 9'd511);
		write_reg(CFG_GRID_ROWS, 9'd0);
		send_map(MAX_WIDTH, 2, 1);
		write_reg(CFG_GRID_WIDTH, 9'd1);
		write_reg(CFG_GRID_ROWS, 9'd256);
		send_map(2, 256, 0);

		// Random small maps, most well formed, a few cut short.
		while (items_sent < TARGET_ITEMS) begin
			w = $urandom_range(2, 9);
			rows = $urandom_range(2, 6);
			write_reg(CFG_GRID_WIDTH, 9'(w));
			write_reg(CFG_GRID_ROWS, 9'(rows));
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				repeat ($urandom_range(1, w * rows))
					send_request(kind_t'($urandom_range(0, 1)), 8'($urandom), 0, '0);
			end else
				send_map(w, rows, mode < 3);
		end

		in_valid <= 1'b0;
		wait_drained();
		if (error_count == 0)
			$display("[heightmap_vertex_normals] OK");
		else
			$display("[heightmap_vertex_normals] ERROR");
		$finish;
	end

	// Receiver stall: short bursts, rare long holds, and one very long hold.
	initial begin
		int r, len;
		bit held;
		held = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && items_sent >= 300) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (2000) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 60) begin
				len = $urandom_range(1, 30);
				out_stall <= 1'b0;
			end else if (r < 95) begin
				len = $urandom_range(1, 4);
				out_stall <= 1'b1;
			end else begin
				len = $urandom_range(20, 80);
				out_stall <= 1'b1;
			end
			repeat (len) @(posedge clk);
		end
	end

	// Compare each taken normal with the oldest expectation.
	always @(posedge clk) begin
		normal_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_normals.size() == 0) begin
				$display("%0t: unexpected normal %0d %0d %0d last %0b", $realtime,
					normal_x, normal_y, normal_z, last_vertex);
				error_count++;
			end else begin
				want = pending_normals.pop_front();
				if (normal_x !== want.nx || normal_y !== want.ny ||
						normal_z !== want.nz || last_vertex !== want.last) begin
					$display("%0t: expected %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
						$realtime, want.nx, want.ny, want.nz, want.last,
						normal_x, normal_y, normal_z, last_vertex);
					error_count++;
				end
			end
		end
	end

	// Timeout.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[heightmap_vertex_normals] ERROR");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule

@@ sim.f @@
+incdir+rtl
rtl/hvn_pkg.sv
rtl/hvn_ram.sv
rtl/hvn_queue.sv
rtl/hvn_front.sv
rtl/hvn_back.sv
rtl/heightmap_vertex_normals.sv
tb/sv/heightmap_vertex_normals_tb.sv
